>>> rtl/pidl_pkg.sv
package pidl_pkg;

  // Field widths fixed by the channel definitions
  localparam int REQ_W  = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;

  // Request codes; the one unused code is ignored
  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_RM_FRONT  = 3'd3,
    REQ_RM_BACK   = 3'd4,
    REQ_RM_POS    = 3'd5,
    REQ_DUMP      = 3'd6
  } req_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Command broadcast to the cell row
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_RM   = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DUMP = 2'd2
  } state_t;

endpackage

>>> rtl/pidl_if.sv
interface pidl_req_if;
  import pidl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface pidl_rsp_if;
  import pidl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic                     elem_valid;
  logic signed [DATA_W-1:0] elem_value;
  logic [CNT_W-1:0]         count;
  logic                     last;

  modport source (output valid, status, elem_valid, elem_value, count, last, input ready);
  modport sink   (input valid, status, elem_valid, elem_value, count, last, output ready);
endinterface

>>> rtl/pidl_cell.sv
module pidl_cell
  import pidl_pkg::*;
#(
  parameter int CW  = 6,
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  cell_op_t                 cmd_op,
  input  logic [CW-1:0]            cmd_pos,
  input  logic [CW-1:0]            cmd_last,
  input  logic signed [DATA_W-1:0] load_val,
  input  logic signed [DATA_W-1:0] prev_q,
  input  logic signed [DATA_W-1:0] next_q,
  input  logic signed [DATA_W-1:0] head_q,
  output logic signed [DATA_W-1:0] q
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic signed [DATA_W-1:0] q_r;
  logic signed [DATA_W-1:0] q_nxt;

  // Pick the source for this cell from the broadcast command
  always_comb begin
    q_nxt = q_r;
    case (cmd_op)
      CELL_INS: begin
        if (MY_IDX == cmd_pos) begin
          q_nxt = load_val;
        end else if (MY_IDX > cmd_pos) begin
          q_nxt = prev_q;
        end
      end
      CELL_RM: begin
        if (MY_IDX >= cmd_pos) begin
          q_nxt = next_q;
        end
      end
      CELL_ROT: begin
        if (MY_IDX == cmd_last) begin
          q_nxt = head_q;
        end else if (MY_IDX < cmd_last) begin
          q_nxt = next_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

>>> rtl/positional_insert_delete_list_core.sv
// Ordered list of up to DEPTH signed 32-bit values held in a row of cells
// that shift in parallel. An edit request (insert or remove at the front, the
// back or a position) is first captured; then, once the output is free, every
// cell at or past the position moves to its neighbor at once and the single
// result is registered. In a dump the row rotates one place per cycle while
// the output is free and the head cell is sent out each time, so after the
// last element the list is back in its original order. An empty dump gives
// one result with elem_valid low. The output register lets a new request be
// taken while a result still waits; a stalled output holds the row in place.
// Reported count is the fill level after the request, low 6 bits.
module positional_insert_delete_list_core
  import pidl_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  pidl_req_if.sink   in_ch,
  pidl_rsp_if.source out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Control state
  state_t        state_r, state_nxt;
  logic [CW-1:0] fill_r,  fill_nxt;
  logic [CW-1:0] idx_r,   idx_nxt;

  // Captured request
  req_t                     req_r,  req_nxt;
  logic [POS_W-1:0]         pos_r,  pos_nxt;
  logic signed [DATA_W-1:0] val_r,  val_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  status_t                  status_r,    status_nxt;
  logic                     evalid_r,    evalid_nxt;
  logic signed [DATA_W-1:0] evalue_r,    evalue_nxt;
  logic [CNT_W-1:0]         count_r,     count_nxt;
  logic                     last_r,      last_nxt;

  // Cell row command
  cell_op_t                 cmd_op;
  logic [CW-1:0]            cmd_pos;
  logic [CW-1:0]            cmd_last;
  logic signed [DATA_W-1:0] cell_q [DEPTH];

  logic          out_free;
  logic [XW-1:0] fill_x;
  logic [XW-1:0] ins_tgt;
  logic [XW-1:0] rm_tgt;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_q;
    logic signed [DATA_W-1:0] next_q;

    if (i == 0) begin : g_head
      assign prev_q = val_r;
    end else begin : g_body
      assign prev_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_q = cell_q[i];
    end else begin : g_inner
      assign next_q = cell_q[i+1];
    end

    pidl_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .cmd_op   (cmd_op),
      .cmd_pos  (cmd_pos),
      .cmd_last (cmd_last),
      .load_val (val_r),
      .prev_q   (prev_q),
      .next_q   (next_q),
      .head_q   (cell_q[0]),
      .q        (cell_q[i])
    );
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign fill_x   = XW'(fill_r);

  // Target positions for the captured request
  always_comb begin
    case (req_r)
      REQ_INS_FRONT: ins_tgt = '0;
      REQ_INS_BACK:  ins_tgt = fill_x;
      default:       ins_tgt = XW'(pos_r);
    endcase
    case (req_r)
      REQ_RM_FRONT: rm_tgt = '0;
      REQ_RM_BACK:  rm_tgt = fill_x - XW'(1);
      default:      rm_tgt = XW'(pos_r);
    endcase
  end

  // Next state, row command and result
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    evalid_nxt    = evalid_r;
    evalue_nxt    = evalue_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    cmd_op        = CELL_HOLD;
    cmd_pos       = '0;
    cmd_last      = '0;
    in_ch.ready   = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        // Capture the request
        if (in_ch.valid) begin
          req_nxt   = req_t'(in_ch.req_type);
          pos_nxt   = in_ch.position;
          val_nxt   = in_ch.value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          state_nxt  = S_IDLE;
          status_nxt = ST_DONE;
          evalid_nxt = 1'b0;
          evalue_nxt = '0;
          last_nxt   = 1'b1;
          case (req_r)
            REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
              out_valid_nxt = 1'b1;
              if (ins_tgt > fill_x) begin
                status_nxt = ST_IGNORED;
              end else if (fill_r == FULL_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                cmd_op   = CELL_INS;
                cmd_pos  = ins_tgt[CW-1:0];
                fill_nxt = fill_r + CW'(1);
              end
            end
            REQ_RM_FRONT, REQ_RM_BACK, REQ_RM_POS: begin
              out_valid_nxt = 1'b1;
              if (fill_r == '0 || rm_tgt >= fill_x) begin
                status_nxt = ST_IGNORED;
              end else begin
                cmd_op   = CELL_RM;
                cmd_pos  = rm_tgt[CW-1:0];
                fill_nxt = fill_r - CW'(1);
              end
            end
            REQ_DUMP: begin
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_IGNORED;
            end
          endcase
          count_nxt = CNT_W'(fill_nxt);
        end
      end

      S_DUMP: begin
        // Send the head cell and rotate the occupied part of the row
        if (out_free) begin
          cmd_op        = CELL_ROT;
          cmd_last      = fill_r - CW'(1);
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DONE;
          evalid_nxt    = 1'b1;
          evalue_nxt    = cell_q[0];
          count_nxt     = CNT_W'(fill_x);
          last_nxt      = (idx_r == fill_r - CW'(1));
          idx_nxt       = idx_r + CW'(1);
          if (idx_r == fill_r - CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    evalid_r <= evalid_nxt;
    evalue_r <= evalue_nxt;
    count_r  <= count_nxt;
    last_r   <= last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.elem_valid = evalid_r;
  assign out_ch.elem_value = evalue_r;
  assign out_ch.count      = count_r;
  assign out_ch.last       = last_r;

endmodule

>>> bench/positional_insert_delete_list_core_tb.sv
`timescale 1ns / 1ps

module positional_insert_delete_list_core_tb;
  import pidl_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  // Request code left unused by the block
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    status_t                  status;
    logic                     elem_valid;
    logic signed [DATA_W-1:0] elem_value;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  pidl_req_if req_ch ();
  pidl_rsp_if rsp_ch ();

  positional_insert_delete_list_core #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(rsp_ch)
  );

  // Requests waiting to be offered, and results the list should produce
  list_req_t req_q[$];
  list_rsp_t due_results[$];

  // Shadow list kept in step with accepted requests
  logic signed [DATA_W-1:0] list_cells [LIST_DEPTH];
  int list_len = 0;

  // Length the generator assumes once every queued request has been applied
  int gen_len = 0;

  int n_queued = 0;
  int n_accepted = 0;
  int err_count = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic req_taken = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Insert into the shadow list; position test comes before the full test
  function automatic status_t list_insert(int pos, logic signed [DATA_W-1:0] v);
    if (pos > list_len) return ST_IGNORED;
    if (list_len >= LIST_DEPTH) return ST_FULL;
    for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
    list_cells[pos] = v;
    list_len++;
    return ST_DONE;
  endfunction

  function automatic status_t list_remove(int pos);
    if (list_len == 0 || pos >= list_len) return ST_IGNORED;
    for (int i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
    list_len--;
    return ST_DONE;
  endfunction

  // Apply one accepted request and queue the results it must cause
  function automatic void apply_request(list_req_t rq);
    status_t   st;
    list_rsp_t r;
    r = '0;
    r.status = ST_DONE;
    r.last = 1'b1;
    if (rq.req_type == REQ_DUMP) begin
      if (list_len == 0) begin
        due_results.push_back(r);
      end else begin
        for (int i = 0; i < list_len; i++) begin
          r.elem_valid = 1'b1;
          r.elem_value = list_cells[i];
          r.count = CNT_W'(list_len);
          r.last = (i == list_len - 1);
          due_results.push_back(r);
        end
      end
      return;
    end
    case (rq.req_type)
      REQ_INS_FRONT: st = list_insert(0, rq.value);
      REQ_INS_BACK:  st = list_insert(list_len, rq.value);
      REQ_INS_POS:   st = list_insert(int'(rq.position), rq.value);
      REQ_RM_FRONT:  st = list_remove(0);
      REQ_RM_BACK:   st = list_remove(list_len - 1);
      REQ_RM_POS:    st = list_remove(int'(rq.position));
      default:       st = ST_IGNORED;
    endcase
    r.status = st;
    r.count = CNT_W'(list_len);
    due_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (err_count < 40)
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Queue one request and track the length it leaves behind
  task automatic push_req(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] v);
    list_req_t rq;
    rq.req_type = kind;
    rq.position = pos;
    rq.value = v;
    req_q.push_back(rq);
    n_queued++;
    case (kind)
      REQ_INS_FRONT, REQ_INS_BACK: if (gen_len < LIST_DEPTH) gen_len++;
      REQ_INS_POS:  if (int'(pos) <= gen_len && gen_len < LIST_DEPTH) gen_len++;
      REQ_RM_FRONT, REQ_RM_BACK: if (gen_len > 0) gen_len--;
      REQ_RM_POS:   if (int'(pos) < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_ins_pos();
    if ($urandom_range(9) == 0) return POS_W'($urandom_range(63, gen_len + 1));
    return POS_W'($urandom_range(gen_len));
  endfunction

  function automatic logic [POS_W-1:0] pick_rm_pos();
    if (gen_len == 0 || $urandom_range(9) == 0) return POS_W'($urandom_range(63));
    return POS_W'($urandom_range(gen_len - 1));
  endfunction

  // Mostly well-formed edits and dumps, with a little raw noise
  task automatic run_random(input int n, input int ins_pct);
    int r;
    int kind;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      kind = $urandom_range(2);
      if (r < 4) begin
        push_req(REQ_W'($urandom_range(7)), POS_W'($urandom_range(63)), $urandom);
      end else if (r < 12) begin
        push_req(REQ_DUMP, POS_W'($urandom_range(63)), $urandom);
      end else if (r < 12 + ins_pct) begin
        case (kind)
          0: push_req(REQ_INS_FRONT, POS_W'($urandom_range(63)), pick_value());
          1: push_req(REQ_INS_BACK, POS_W'($urandom_range(63)), pick_value());
          default: push_req(REQ_INS_POS, pick_ins_pos(), pick_value());
        endcase
      end else begin
        case (kind)
          0: push_req(REQ_RM_FRONT, POS_W'($urandom_range(63)), $urandom);
          1: push_req(REQ_RM_BACK, POS_W'($urandom_range(63)), $urandom);
          default: push_req(REQ_RM_POS, pick_rm_pos(), $urandom);
        endcase
      end
    end
  endtask

  // Hold until every queued request is taken and every result has come
  task automatic wait_drained();
    @(negedge clk);
    while (n_accepted != n_queued || due_results.size() != 0) @(negedge clk);
  endtask

  // Offer requests from the pending queue, with random gaps
  always @(negedge clk) begin : drive_req
    list_req_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_DUMP;
      req_ch.position <= '0;
      req_ch.value <= '0;
    end else if (!(req_ch.valid && !req_taken)) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.req_type <= nxt.req_type;
        req_ch.position <= nxt.position;
        req_ch.value <= nxt.value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random, or for a long hold-off on request
  always @(negedge clk) begin : drive_rsp_ready
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Check each result transfer, then predict from each request transfer
  always @(posedge clk) begin : monitor
    list_rsp_t want;
    list_req_t rq;
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing expected", rsp_ch.elem_value, '0);
        end else begin
          want = due_results.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", DATA_W'(rsp_ch.status), DATA_W'(want.status));
          if (rsp_ch.elem_valid !== want.elem_valid)
            report_mismatch("elem_valid", DATA_W'(rsp_ch.elem_valid),
                            DATA_W'(want.elem_valid));
          if (rsp_ch.elem_value !== want.elem_value)
            report_mismatch("elem_value", rsp_ch.elem_value, want.elem_value);
          if (rsp_ch.count !== want.count)
            report_mismatch("count", DATA_W'(rsp_ch.count), DATA_W'(want.count));
          if (rsp_ch.last !== want.last)
            report_mismatch("last", DATA_W'(rsp_ch.last), DATA_W'(want.last));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        rq.req_type = req_ch.req_type;
        rq.position = req_ch.position;
        rq.value = req_ch.value;
        apply_request(rq);
        n_accepted++;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list cases, extremes, out-of-range positions, unused code
    push_req(REQ_DUMP, '0, '0);
    push_req(REQ_RM_FRONT, '0, '0);
    push_req(REQ_RM_BACK, '0, '0);
    push_req(REQ_RM_POS, '0, '0);
    push_req(REQ_INS_POS, 6'd1, 32'sd5);
    push_req(REQ_INS_FRONT, '0, 32'sh8000_0000);
    push_req(REQ_INS_BACK, 6'd63, 32'sh7fff_ffff);
    push_req(REQ_INS_POS, 6'd1, -32'sd1);
    push_req(REQ_INS_POS, 6'd0, '0);
    push_req(REQ_INS_POS, 6'd4, 32'sh5555_5555);
    push_req(REQ_INS_POS, 6'd2, 32'shaaaa_aaaa);
    push_req(REQ_DUMP, 6'd63, -32'sd1);
    push_req(REQ_RM_POS, 6'd63, '0);
    push_req(REQ_RM_POS, 6'd6, '0);
    push_req(REQ_INS_POS, 6'd63, 32'sd7);
    push_req(REQ_UNUSED, 6'd63, -32'sd1);
    push_req(REQ_RM_POS, 6'd2, '0);
    push_req(REQ_RM_FRONT, '0, '0);
    push_req(REQ_RM_BACK, '0, '0);
    push_req(REQ_RM_POS, '0, '0);
    push_req(REQ_DUMP, '0, '0);
    wait_drained();

    // Fill to capacity, then hit the full and past-the-end cases
    while (gen_len < LIST_DEPTH) begin
      case ($urandom_range(2))
        0: push_req(REQ_INS_FRONT, '0, pick_value());
        1: push_req(REQ_INS_BACK, '0, pick_value());
        default: push_req(REQ_INS_POS, POS_W'($urandom_range(gen_len)), pick_value());
      endcase
    end
    push_req(REQ_INS_POS, POS_W'(LIST_DEPTH + 1), 32'sd1);
    push_req(REQ_INS_POS, POS_W'(LIST_DEPTH), 32'sd2);
    push_req(REQ_INS_FRONT, '0, 32'sd3);
    push_req(REQ_INS_BACK, '0, 32'sd4);
    push_req(REQ_DUMP, '0, '0);
    run_random(10, 50);
    wait_drained();

    // Sender idles often
    send_idle_pct = 57;
    rsp_stall_pct = 0;
    run_random(15, 40);
    wait_drained();

    // Receiver stalls often
    send_idle_pct = 0;
    rsp_stall_pct = 57;
    run_random(15, 55);
    wait_drained();

    // Light idling on both sides
    send_idle_pct = 9;
    rsp_stall_pct = 9;
    run_random(15, 50);
    wait_drained();

    // Long receiver hold-off while requests keep coming, then drain to empty
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_seq++;
    run_random(15, 45);
    while (gen_len > 0) begin
      case ($urandom_range(2))
        0: push_req(REQ_RM_FRONT, '0, '0);
        1: push_req(REQ_RM_BACK, '0, '0);
        default: push_req(REQ_RM_POS, POS_W'($urandom_range(gen_len - 1)), '0);
      endcase
    end
    push_req(REQ_DUMP, '0, '0);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0 && due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
